// ===== design/ltsp_pkg.sv =====
// Shared types and constants of the logo table section parser.
package ltsp_pkg;

  typedef enum logic [1:0] {
    REC_HEADER     = 2'd0,
    REC_ENTRY_HEAD = 2'd1,
    REC_DATA       = 2'd2
  } rec_kind_t;

  typedef struct packed {
    logic [7:0]  table_ident;
    logic [15:0] download_ident;
    logic [4:0]  version;
    logic [15:0] network_ident;
    logic [7:0]  content_type;
  } hdr_t;

  typedef struct packed {
    logic [7:0]  logo_kind;
    logic [8:0]  logo_number;
    logic [11:0] logo_revision;
  } ent_t;

  typedef struct packed {
    rec_kind_t   kind;
    hdr_t        hdr;
    ent_t        ent;
    logic [15:0] payload_size;
    logic [7:0]  payload_byte;
    logic        entry_last;
  } rec_t;

  localparam logic [3:0]  HDR_LAST_IDX   = 4'd12;
  localparam logic [3:0]  ENT_LAST_IDX   = 4'd6;
  localparam logic [12:0] HDR_FIXED_LEN  = 13'd14;

endpackage

// ===== design/ltsp_front.sv =====
// Byte parser: tracks section structure and turns header, entry head and data bytes into record requests.
module ltsp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         section_byte,
  input  logic               section_start,
  output logic               rec_valid,
  output ltsp_pkg::rec_t     rec
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DESC_HEAD,
    PH_DESC_BODY,
    PH_ENTRY_HEAD,
    PH_ENTRY_DATA,
    PH_TRAILER
  } phase_t;

  phase_t               phase, phase_next, cur;
  logic [3:0]           idx, idx_next, cur_idx;
  logic [11:0]          section_len, section_len_next;
  logic [11:0]          desc_left, desc_left_next, desc_dec;
  logic [7:0]           body_left, body_left_next, body_dec;
  logic [11:0]          data_left, data_left_next, data_dec;
  logic [15:0]          payload_left, payload_left_next, payload_dec, payload_full;
  ltsp_pkg::hdr_t       hdr, hdr_next;
  ltsp_pkg::ent_t       ent, ent_next;
  logic [11:0]          desc_full;
  logic [12:0]          fixed_sum;
  logic                 emit;
  ltsp_pkg::rec_t       rec_c;

  assign desc_dec    = (desc_left != '0) ? desc_left - 12'd1 : '0;
  assign body_dec    = (body_left != '0) ? body_left - 8'd1 : '0;
  assign data_dec    = (data_left != '0) ? data_left - 12'd1 : '0;
  assign payload_dec = (payload_left != '0) ? payload_left - 16'd1 : '0;
  assign desc_full   = {desc_left[11:8], section_byte};
  assign fixed_sum   = {1'b0, desc_full} + ltsp_pkg::HDR_FIXED_LEN;
  assign payload_full = {payload_left[15:8], section_byte};

  always_comb begin
    phase_next        = phase;
    idx_next          = idx;
    section_len_next  = section_len;
    desc_left_next    = desc_left;
    body_left_next    = body_left;
    data_left_next    = data_left;
    payload_left_next = payload_left;
    hdr_next          = hdr;
    ent_next          = ent;
    emit              = 1'b0;
    rec_c             = '0;
    rec_c.hdr         = hdr;
    rec_c.ent         = ent;
    rec_c.kind        = ltsp_pkg::REC_HEADER;
    cur               = phase;
    cur_idx           = idx;
    if (section_start) begin
      cur              = PH_HEADER;
      cur_idx          = '0;
      phase_next       = PH_HEADER;
      section_len_next = '0;
      desc_left_next   = '0;
      data_left_next   = '0;
    end
    unique case (cur)
      PH_HEADER: begin
        case (cur_idx)
          4'd0:  hdr_next.table_ident          = section_byte;
          4'd1:  section_len_next              = {section_byte[3:0], 8'h00};
          4'd2:  section_len_next              = {section_len[11:8], section_byte};
          4'd3:  hdr_next.download_ident[15:8] = section_byte;
          4'd4:  hdr_next.download_ident[7:0]  = section_byte;
          4'd5:  hdr_next.version              = section_byte[5:1];
          4'd8:  hdr_next.network_ident[15:8]  = section_byte;
          4'd9:  hdr_next.network_ident[7:0]   = section_byte;
          4'd10: hdr_next.content_type         = section_byte;
          4'd11: desc_left_next                = {section_byte[3:0], 8'h00};
          default: ;
        endcase
        if (cur_idx < ltsp_pkg::HDR_LAST_IDX) begin
          idx_next = cur_idx + 4'd1;
        end else begin
          desc_left_next = desc_full;
          if ({1'b0, section_len} > fixed_sum) begin
            data_left_next = 12'({1'b0, section_len} - fixed_sum);
          end else begin
            data_left_next = '0;
          end
          idx_next = '0;
          if (desc_full != '0) begin
            phase_next = PH_DESC_HEAD;
          end else if (data_left_next != '0) begin
            phase_next = PH_ENTRY_HEAD;
          end else begin
            phase_next = PH_TRAILER;
          end
          emit       = 1'b1;
          rec_c.kind = ltsp_pkg::REC_HEADER;
        end
      end
      PH_DESC_HEAD: begin
        desc_left_next = desc_dec;
        if (cur_idx == '0) begin
          idx_next = 4'd1;
        end else begin
          body_left_next = section_byte;
          idx_next       = '0;
          if (section_byte != '0) begin
            phase_next = PH_DESC_BODY;
          end else if (desc_dec != '0) begin
            phase_next = PH_DESC_HEAD;
          end else if (data_left != '0) begin
            phase_next = PH_ENTRY_HEAD;
          end else begin
            phase_next = PH_TRAILER;
          end
        end
      end
      PH_DESC_BODY: begin
        desc_left_next = desc_dec;
        body_left_next = body_dec;
        if (body_dec == '0) begin
          idx_next = '0;
          if (desc_dec != '0) begin
            phase_next = PH_DESC_HEAD;
          end else if (data_left != '0) begin
            phase_next = PH_ENTRY_HEAD;
          end else begin
            phase_next = PH_TRAILER;
          end
        end
      end
      PH_ENTRY_HEAD: begin
        data_left_next = data_dec;
        case (cur_idx)
          4'd0: begin
            ent_next           = '0;
            ent_next.logo_kind = section_byte;
          end
          4'd1: ent_next.logo_number[8]        = section_byte[0];
          4'd2: ent_next.logo_number[7:0]      = section_byte;
          4'd3: ent_next.logo_revision[11:8]   = section_byte[3:0];
          4'd4: ent_next.logo_revision[7:0]    = section_byte;
          4'd5: payload_left_next              = {section_byte, 8'h00};
          default: ;
        endcase
        if (cur_idx < ltsp_pkg::ENT_LAST_IDX) begin
          idx_next = cur_idx + 4'd1;
        end else begin
          payload_left_next  = payload_full;
          idx_next           = '0;
          emit               = 1'b1;
          rec_c.kind         = ltsp_pkg::REC_ENTRY_HEAD;
          rec_c.payload_size = payload_full;
          rec_c.entry_last   = (payload_full == '0);
          if (payload_full != '0) begin
            phase_next = PH_ENTRY_DATA;
          end else if (data_dec == '0) begin
            phase_next = PH_TRAILER;
          end else begin
            phase_next = PH_ENTRY_HEAD;
          end
        end
      end
      PH_ENTRY_DATA: begin
        data_left_next     = data_dec;
        payload_left_next  = payload_dec;
        emit               = 1'b1;
        rec_c.kind         = ltsp_pkg::REC_DATA;
        rec_c.payload_byte = section_byte;
        rec_c.entry_last   = (payload_dec == '0);
        if (payload_dec == '0) begin
          idx_next   = '0;
          phase_next = (data_dec == '0) ? PH_TRAILER : PH_ENTRY_HEAD;
        end
      end
      default: ;
    endcase
  end

  assign rec_valid = take && emit;
  assign rec       = rec_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      idx          <= '0;
      section_len  <= '0;
      desc_left    <= '0;
      body_left    <= '0;
      data_left    <= '0;
      payload_left <= '0;
      hdr          <= '0;
      ent          <= '0;
    end else if (take) begin
      phase        <= phase_next;
      idx          <= idx_next;
      section_len  <= section_len_next;
      desc_left    <= desc_left_next;
      body_left    <= body_left_next;
      data_left    <= data_left_next;
      payload_left <= payload_left_next;
      hdr          <= hdr_next;
      ent          <= ent_next;
    end
  end

endmodule

// ===== design/ltsp_queue.sv =====
// Record request queue between the byte parser and the output stage.
module ltsp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  ltsp_pkg::rec_t wr_rec,
  input  logic           rd,
  output ltsp_pkg::rec_t rd_rec,
  output logic           full,
  output logic           nonempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ltsp_pkg::rec_t  store [DEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign do_wr    = wr && !full;
  assign do_rd    = rd && nonempty;
  assign rd_rec   = store[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== design/ltsp_back.sv =====
// Output stage: takes record requests from the queue, formats and holds them for the receiver.
module ltsp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_nonempty,
  input  ltsp_pkg::rec_t q_rec,
  output logic           q_rd,
  input  logic           pop,
  output logic           empty,
  output ltsp_pkg::rec_t out_rec
);

  logic           out_valid;
  ltsp_pkg::rec_t fmt;

  // drop entry fields from header records
  always_comb begin
    fmt = q_rec;
    if (q_rec.kind == ltsp_pkg::REC_HEADER) begin
      fmt.ent = '0;
    end
  end

  assign q_rd  = q_nonempty && (!out_valid || pop);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      out_rec <= fmt;
    end
  end

endmodule

// ===== design/logo_table_section_parser.sv =====
// Top level of the logo table section parser.
// Input channel: one section byte per request, with section_start high on the
// first byte of a section; a request is taken when push is high and full low.
// Output channel: one record per request (section header, logo entry head or
// logo data byte); the oldest record sits on the result ports while empty is
// low and is taken when pop is high.
// Throughput: one byte per cycle; the byte parser does a single state update
// per byte and never waits on the output side while the record queue has room.
// A record caused by a taken byte is written into the queue and then into the
// output register, from which it is shown on the result ports.
// When the receiver stalls, up to QUEUE_DEPTH records wait in the queue plus
// one in the output register; full rises once the queue is full, even for
// bytes that would give no record.
// Reset: parser returns to idle (waits for a start byte), queue and output
// register are emptied.
module logo_table_section_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  section_byte,
  input  logic        section_start,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  record_kind,
  output logic [7:0]  table_ident,
  output logic [15:0] download_ident,
  output logic [4:0]  version,
  output logic [15:0] network_ident,
  output logic [7:0]  content_type,
  output logic [7:0]  logo_kind,
  output logic [8:0]  logo_number,
  output logic [11:0] logo_revision,
  output logic [15:0] payload_size,
  output logic [7:0]  payload_byte,
  output logic        entry_last
);

  logic           take;
  logic           rec_valid;
  ltsp_pkg::rec_t rec;
  ltsp_pkg::rec_t q_rec;
  ltsp_pkg::rec_t out_rec;
  logic           q_full, q_nonempty, q_rd;

  assign full = q_full;
  assign take = push && !q_full;

  ltsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .section_byte  (section_byte),
    .section_start (section_start),
    .rec_valid     (rec_valid),
    .rec           (rec)
  );

  ltsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (rec_valid),
    .wr_rec   (rec),
    .rd       (q_rd),
    .rd_rec   (q_rec),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  ltsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_rec      (q_rec),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_rec    (out_rec)
  );

  assign record_kind    = out_rec.kind;
  assign table_ident    = out_rec.hdr.table_ident;
  assign download_ident = out_rec.hdr.download_ident;
  assign version        = out_rec.hdr.version;
  assign network_ident  = out_rec.hdr.network_ident;
  assign content_type   = out_rec.hdr.content_type;
  assign logo_kind      = out_rec.ent.logo_kind;
  assign logo_number    = out_rec.ent.logo_number;
  assign logo_revision  = out_rec.ent.logo_revision;
  assign payload_size   = out_rec.payload_size;
  assign payload_byte   = out_rec.payload_byte;
  assign entry_last     = out_rec.entry_last;

endmodule
